### hdl/imusbc_pkg.sv
// Shared types, sizes and codes for the IMU static bias calibration block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package imusbc_pkg;

    // Field and arithmetic sizes.
    localparam int FIELD_BITS   = 32;
    localparam int SAMPLE_BITS  = 32;
    localparam int COUNT_BITS   = 24;
    localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
    localparam int OUT_CNT_BITS = 24;
    localparam int NUM_AXES     = 6;
    localparam int AXIS_BITS    = $clog2(NUM_AXES);
    localparam int STEP_BITS    = $clog2(SUM_BITS + 1);
    localparam int WIDE_BITS    = FIELD_BITS + 3;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRAVITY = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EARTH_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EARTH_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_EARTH_Z = 3'd4;

    // Axis slots.
    localparam logic [AXIS_BITS-1:0] AXIS_ACC_Z = AXIS_BITS'(2);
    localparam logic [AXIS_BITS-1:0] AXIS_GYR_X = AXIS_BITS'(3);
    localparam logic [AXIS_BITS-1:0] AXIS_LAST  = AXIS_BITS'(NUM_AXES - 1);

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    typedef struct packed {
        logic                          start_new;
        logic signed [FIELD_BITS-1:0]  acc_x_in;
        logic signed [FIELD_BITS-1:0]  acc_y_in;
        logic signed [FIELD_BITS-1:0]  acc_z_in;
        logic signed [FIELD_BITS-1:0]  gyr_x_in;
        logic signed [FIELD_BITS-1:0]  gyr_y_in;
        logic signed [FIELD_BITS-1:0]  gyr_z_in;
    } imu_in_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0]  acc_x_out;
        logic signed [FIELD_BITS-1:0]  acc_y_out;
        logic signed [FIELD_BITS-1:0]  acc_z_out;
        logic signed [FIELD_BITS-1:0]  gyr_x_out;
        logic signed [FIELD_BITS-1:0]  gyr_y_out;
        logic signed [FIELD_BITS-1:0]  gyr_z_out;
        logic [OUT_CNT_BITS-1:0]       samples_seen;
        logic [1:0]                    status;
    } imu_out_t;

endpackage

`default_nettype wire

### hdl/imusbc_div.sv
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
// Depends on imusbc_pkg for the sum, count and sample widths.
`default_nettype none

module imusbc_div
    import imusbc_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [SUM_BITS-1:0]    dividend,
    input  wire logic [COUNT_BITS-1:0]         divisor,
    output logic                               done,
    output logic signed [SAMPLE_BITS-1:0]      quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [COUNT_BITS-1:0]    rem_reg, rem_next;
    logic [SUM_BITS-1:0]      quo_reg, quo_next;
    logic [COUNT_BITS-1:0]    dvs_reg, dvs_next;
    logic                     neg_reg, neg_next;
    logic [SUM_BITS-1:0]      mag;
    logic [COUNT_BITS:0]      shifted;
    logic [COUNT_BITS:0]      trial;
    logic [SAMPLE_BITS-1:0]   quo_low;

    // Magnitude of the dividend; the sign is restored at the end.
    assign mag = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_BITS'(SUM_BITS);
            rem_next  = '0;
            quo_next  = mag;
            dvs_next  = divisor;
            neg_next  = dividend[SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            if (trial[COUNT_BITS])
            begin
                rem_next = shifted[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_BITS-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[COUNT_BITS-1:0];
                quo_next = {quo_reg[SUM_BITS-2:0], 1'b1};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // The mean always fits the sample width, so the low bits carry it.
    assign quo_low  = quo_reg[SAMPLE_BITS-1:0];
    assign quotient = neg_reg ? signed'(-quo_low) : signed'(quo_low);
    assign done     = done_reg;

endmodule

`default_nettype wire

### hdl/imu_static_bias_calibrate.sv
// IMU static bias calibration: running means in accumulate mode, bias removal in compensate.
// With no samples yet the divider is skipped and the mean is taken as zero.
// A new sample is taken only after the last result has moved to the output register; the
// shared 56-by-24 divider works on one axis at a time.
// Reset: rst_n clears configuration, sums, count and handshake state asynchronously.
// Depends on imusbc_pkg and imusbc_div.
`default_nettype none

module imu_static_bias_calibrate
    import imusbc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [FIELD_BITS-1:0]    cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire imu_in_t                  in_data,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output imu_out_t                      out_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ACCUM = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_COMB  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // Configuration registers.
    logic                          mode_reg;
    logic signed [FIELD_BITS-1:0]  gravity_reg;
    logic signed [FIELD_BITS-1:0]  earth_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            gravity_reg <= '0;
            earth_reg[0] <= '0;
            earth_reg[1] <= '0;
            earth_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg     <= cfg_data[0];
                REG_GRAVITY: gravity_reg  <= signed'(cfg_data);
                REG_EARTH_X: earth_reg[0] <= signed'(cfg_data);
                REG_EARTH_Y: earth_reg[1] <= signed'(cfg_data);
                REG_EARTH_Z: earth_reg[2] <= signed'(cfg_data);
                default:     ;
            endcase
        end
    end

    // Sequencer and datapath state.
    logic [2:0]                     state_reg, state_next;
    logic [AXIS_BITS-1:0]           axis_reg, axis_next;
    logic [COUNT_BITS-1:0]          count_reg, count_next;
    logic                           clr_reg, clr_next;
    logic                           full_reg, full_next;
    logic                           sat_reg, sat_next;
    logic                           out_valid_reg, out_valid_next;
    imu_out_t                       out_reg;
    logic signed [SUM_BITS-1:0]     sum_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0]  smp_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0]  res_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0]  mean_reg, mean_next;
    logic signed [SUM_BITS-1:0]     sum_next;
    logic                           sum_we;
    logic                           res_we;
    logic                           smp_we;
    logic                           out_load;
    logic                           in_xfer;
    logic [COUNT_BITS-1:0]          cnt_eff;

    // Shared divider.
    logic                           div_start;
    logic                           div_done;
    logic signed [SAMPLE_BITS-1:0]  div_quo;

    imusbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[axis_reg]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Accumulate step for the selected axis.
    logic signed [SUM_BITS-1:0]  sum_base;
    logic signed [SUM_BITS-1:0]  sum_add;
    logic signed [SAMPLE_BITS-1:0] smp_sel;

    assign smp_sel  = smp_reg[axis_reg];
    assign sum_base = clr_reg ? '0 : sum_reg[axis_reg];
    assign sum_add  = full_reg ? '0 : SUM_BITS'(smp_sel);

    // Bias removal and saturation for the selected axis.
    logic signed [WIDE_BITS-1:0]    adj_w;
    logic signed [WIDE_BITS-1:0]    diff_w;
    logic signed [WIDE_BITS-1:0]    val_w;
    logic [WIDE_BITS-SAMPLE_BITS:0] top_bits;
    logic                           over;
    logic                           under;
    logic signed [SAMPLE_BITS-1:0]  clipped;

    always_comb
    begin
        if (axis_reg == AXIS_ACC_Z)
            adj_w = WIDE_BITS'(gravity_reg);
        else if (axis_reg >= AXIS_GYR_X)
            adj_w = -WIDE_BITS'(earth_reg[2'(axis_reg - AXIS_GYR_X)]);
        else
            adj_w = '0;
    end

    assign diff_w   = WIDE_BITS'(smp_sel) - (WIDE_BITS'(mean_reg) + adj_w);
    assign val_w    = mode_reg ? diff_w : WIDE_BITS'(mean_reg);
    assign top_bits = val_w[WIDE_BITS-1:SAMPLE_BITS-1];
    assign over     = !val_w[WIDE_BITS-1] && (top_bits != '0);
    assign under    = val_w[WIDE_BITS-1] && (top_bits != '1);

    always_comb
    begin
        if (over)
            clipped = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (under)
            clipped = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            clipped = val_w[SAMPLE_BITS-1:0];
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign cnt_eff  = in_data.start_new ? '0 : count_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        full_next      = full_reg;
        sat_next       = sat_reg;
        mean_next      = mean_reg;
        sum_next       = sum_base + sum_add;
        sum_we         = 1'b0;
        res_we         = 1'b0;
        smp_we         = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    smp_we    = 1'b1;
                    axis_next = '0;
                    sat_next  = 1'b0;
                    if (!mode_reg)
                    begin
                        clr_next   = in_data.start_new;
                        full_next  = (cnt_eff == CMAX);
                        count_next = (cnt_eff == CMAX) ? cnt_eff : cnt_eff + 1'b1;
                        state_next = ST_ACCUM;
                    end
                    else
                    begin
                        clr_next   = 1'b0;
                        full_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_ACCUM:
            begin
                sum_we = 1'b1;
                if (axis_reg == AXIS_LAST)
                begin
                    axis_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (count_reg == '0)
                begin
                    mean_next  = '0;
                    state_next = ST_COMB;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    mean_next  = div_quo;
                    state_next = ST_COMB;
                end
            end
            ST_COMB:
            begin
                res_we = 1'b1;
                if (mode_reg && (over || under))
                    sat_next = 1'b1;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= 1'b0;
            full_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            full_reg      <= full_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (sum_we)
                sum_reg[axis_reg] <= sum_next;
        end
    end

    // Result status for the finished item.
    logic [1:0] status_w;

    always_comb
    begin
        if (!mode_reg)
            status_w = full_reg ? STAT_FULL : STAT_OK;
        else if (sat_reg)
            status_w = STAT_SAT;
        else if (count_reg == '0)
            status_w = STAT_EMPTY;
        else
            status_w = STAT_OK;
    end

    // Payload registers: captured samples, per-axis results and the output stage.
    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        if (smp_we)
        begin
            smp_reg[0] <= in_data.acc_x_in[SAMPLE_BITS-1:0];
            smp_reg[1] <= in_data.acc_y_in[SAMPLE_BITS-1:0];
            smp_reg[2] <= in_data.acc_z_in[SAMPLE_BITS-1:0];
            smp_reg[3] <= in_data.gyr_x_in[SAMPLE_BITS-1:0];
            smp_reg[4] <= in_data.gyr_y_in[SAMPLE_BITS-1:0];
            smp_reg[5] <= in_data.gyr_z_in[SAMPLE_BITS-1:0];
        end
        if (res_we)
            res_reg[axis_reg] <= clipped;
        if (out_load)
        begin
            out_reg.acc_x_out    <= FIELD_BITS'(res_reg[0]);
            out_reg.acc_y_out    <= FIELD_BITS'(res_reg[1]);
            out_reg.acc_z_out    <= FIELD_BITS'(res_reg[2]);
            out_reg.gyr_x_out    <= FIELD_BITS'(res_reg[3]);
            out_reg.gyr_y_out    <= FIELD_BITS'(res_reg[4]);
            out_reg.gyr_z_out    <= FIELD_BITS'(res_reg[5]);
            out_reg.samples_seen <= OUT_CNT_BITS'(count_reg);
            out_reg.status       <= status_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait step");

    // A transfer in closes the input until the item is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened right after a transfer");

    // Sums change only in accumulate mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCUM) |-> !mode_reg)
        else $error("accumulate step in compensate mode");

    // A full count is only reported in accumulate mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == STAT_FULL)) |-> !mode_reg)
        else $error("count full reported in compensate mode");
`endif

endmodule

`default_nettype wire

### tb/sv/imu_static_bias_calibrate_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for imu_static_bias_calibrate: directed and random IMU samples,
// with a scoreboard class that predicts running means and bias-compensated outputs.
// Depends on imusbc_pkg and the imu_static_bias_calibrate RTL.

module imu_static_bias_calibrate_test;
    import imusbc_pkg::*;

    // Predicts each result from the accepted samples and checks results in order.
    class bias_scoreboard;
        bit        compensate;
        longint    gravity;
        longint    earth[3];
        longint    sums[NUM_AXES];
        longint    count;
        imu_out_t  expected[$];
        int        errors;
        int        n_checked;
        int        n_sat;
        int        n_empty;
        string     axis_names[NUM_AXES];

        function new();
            axis_names = '{"acc_x", "acc_y", "acc_z", "gyr_x", "gyr_y", "gyr_z"};
        endfunction

        // Low SAMPLE_BITS of a field, sign-extended.
        function longint widen(logic [FIELD_BITS-1:0] v);
            longint w;
            w = longint'(v);
            return (w <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
        endfunction

        function longint saturate(longint v, inout bit clipped);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
            begin
                clipped = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                clipped = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // Division truncates toward zero, as the block does.
        function longint mean_of(int k);
            if (count == 0)
                return 0;
            return sums[k] / count;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [FIELD_BITS-1:0] v);
            case (idx)
                REG_MODE:    compensate = v[0];
                REG_GRAVITY: gravity = longint'($signed(v));
                REG_EARTH_X: earth[0] = longint'($signed(v));
                REG_EARTH_Y: earth[1] = longint'($signed(v));
                REG_EARTH_Z: earth[2] = longint'($signed(v));
                default:     ;
            endcase
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // In accumulate mode updates the sums and count for one accepted sample; queues its result.
        function void take_sample(imu_in_t d);
            longint   raw[NUM_AXES];
            longint   res[NUM_AXES];
            longint   bias;
            logic [1:0] st;
            bit       clipped;
            imu_out_t e;
            int       k;
            raw = '{widen(d.acc_x_in), widen(d.acc_y_in), widen(d.acc_z_in),
                    widen(d.gyr_x_in), widen(d.gyr_y_in), widen(d.gyr_z_in)};
            st = STAT_OK;
            clipped = 1'b0;
            if (!compensate)
            begin
                if (d.start_new)
                begin
                    for (k = 0; k < NUM_AXES; k++)
                        sums[k] = 0;
                    count = 0;
                end
                if (count >= (longint'(1) <<< COUNT_BITS) - 1)
                    st = STAT_FULL;
                else
                begin
                    for (k = 0; k < NUM_AXES; k++)
                        sums[k] += raw[k];
                    count++;
                end
                for (k = 0; k < NUM_AXES; k++)
                    res[k] = saturate(mean_of(k), clipped);
            end
            else
            begin
                for (k = 0; k < NUM_AXES; k++)
                begin
                    bias = mean_of(k);
                    if (k == AXIS_ACC_Z)
                        bias += gravity;
                    else if (k >= AXIS_GYR_X)
                        bias -= earth[k - AXIS_GYR_X];
                    res[k] = saturate(raw[k] - bias, clipped);
                end
                if (clipped)
                    st = STAT_SAT;
                else if (count == 0)
                    st = STAT_EMPTY;
            end
            e.acc_x_out = FIELD_BITS'(res[0]);
            e.acc_y_out = FIELD_BITS'(res[1]);
            e.acc_z_out = FIELD_BITS'(res[2]);
            e.gyr_x_out = FIELD_BITS'(res[3]);
            e.gyr_y_out = FIELD_BITS'(res[4]);
            e.gyr_z_out = FIELD_BITS'(res[5]);
            e.samples_seen = OUT_CNT_BITS'(count);
            e.status = st;
            expected.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(imu_out_t got);
            imu_out_t want;
            logic [FIELD_BITS-1:0] g[NUM_AXES];
            logic [FIELD_BITS-1:0] w[NUM_AXES];
            int k;
            n_checked++;
            if (expected.size() == 0)
            begin
                report($sformatf("result %0d arrived with none expected", n_checked));
                return;
            end
            want = expected.pop_front();
            g = '{got.acc_x_out, got.acc_y_out, got.acc_z_out,
                  got.gyr_x_out, got.gyr_y_out, got.gyr_z_out};
            w = '{want.acc_x_out, want.acc_y_out, want.acc_z_out,
                  want.gyr_x_out, want.gyr_y_out, want.gyr_z_out};
            for (k = 0; k < NUM_AXES; k++)
                if (g[k] !== w[k])
                    report($sformatf("result %0d %s: got %0d, expected %0d", n_checked,
                                     axis_names[k], $signed(g[k]), $signed(w[k])));
            if (got.samples_seen !== want.samples_seen)
                report($sformatf("result %0d samples_seen: got %0d, expected %0d", n_checked,
                                 got.samples_seen, want.samples_seen));
            if (got.status !== want.status)
                report($sformatf("result %0d status: got %0d, expected %0d", n_checked,
                                 got.status, want.status));
            if (want.status == STAT_SAT)
                n_sat++;
            if (want.status == STAT_EMPTY)
                n_empty++;
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [FIELD_BITS-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    imu_in_t                  in_data;
    logic                     out_valid;
    logic                     out_ready;
    imu_out_t                 out_data;

    bias_scoreboard board = new();
    int hold_request;
    bit idling_on;

    imu_static_bias_calibrate uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock generation.
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog against a hung handshake.
    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: checks each transfer, stalls in random bursts or for a requested hold.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(out_data);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offers one sample and holds it until the transfer; valid stays high for the caller.
    task automatic send_sample(imu_in_t d);
        in_valid <= 1'b1;
        in_data <= d;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_sample(d);
    endtask

    task automatic send_with_idle(imu_in_t d);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_sample(d);
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Writes all five registers one after another; only called while the block is idle.
    task automatic configure(bit m, logic [FIELD_BITS-1:0] grav, logic [FIELD_BITS-1:0] ex,
                             logic [FIELD_BITS-1:0] ey, logic [FIELD_BITS-1:0] ez);
        logic [CFG_IDX_BITS-1:0] idx[5];
        logic [FIELD_BITS-1:0]   val[5];
        int i;
        idx = '{REG_MODE, REG_GRAVITY, REG_EARTH_X, REG_EARTH_Y, REG_EARTH_Z};
        val = '{FIELD_BITS'(m), grav, ex, ey, ez};
        for (i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            board.write_reg(idx[i], val[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic imu_in_t uniform_sample(bit start, logic [FIELD_BITS-1:0] v);
        imu_in_t d;
        d.start_new = start;
        d.acc_x_in = v;
        d.acc_y_in = v;
        d.acc_z_in = v;
        d.gyr_x_in = v;
        d.gyr_y_in = v;
        d.gyr_z_in = v;
        return d;
    endfunction

    // Mix of full-scale extremes, small values and fully random words.
    function automatic logic [FIELD_BITS-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3, 4: return FIELD_BITS'(int'($urandom_range(0, 4000)) - 2000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_setting();
        case ($urandom_range(0, 4))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return FIELD_BITS'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic imu_in_t rand_sample();
        imu_in_t d;
        d.start_new = ($urandom_range(0, 25) == 0);
        d.acc_x_in = rand_word();
        d.acc_y_in = rand_word();
        d.acc_z_in = rand_word();
        d.gyr_x_in = rand_word();
        d.gyr_y_in = rand_word();
        d.gyr_z_in = rand_word();
        return d;
    endfunction

    // Stimulus sequence.
    initial
    begin : stimulus
        int phase;
        int i;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        hold_request = 0;
        idling_on = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Compensate with no calibration samples: the start flag is ignored, and
        // saturation overrides the empty status.
        configure(1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_sample(uniform_sample(1'b1, 32'h0));
        send_sample(uniform_sample(1'b0, 32'h7fff_ffff));
        send_sample(uniform_sample(1'b0, 32'h8000_0000));
        drain();

        // Accumulate: full-scale sums, bit patterns, and truncation toward zero of
        // negative means. A full count needs 2^24 - 1 samples, far beyond this run.
        configure(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(uniform_sample(1'b1, 32'h7fff_ffff));
        send_sample(uniform_sample(1'b0, 32'h7fff_ffff));
        send_sample(uniform_sample(1'b0, 32'h8000_0000));
        send_sample(uniform_sample(1'b0, 32'h8000_0000));
        send_sample(uniform_sample(1'b0, 32'h5555_5555));
        send_sample(uniform_sample(1'b0, 32'haaaa_aaaa));
        send_sample(uniform_sample(1'b1, -32'sd7));
        send_sample(uniform_sample(1'b0, 32'd2));
        send_sample(uniform_sample(1'b0, 32'd1));
        drain();

        // Compensate against the stored means with opposite extreme settings.
        configure(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
        send_sample(uniform_sample(1'b1, 32'h7fff_ffff));
        send_sample(uniform_sample(1'b0, 32'h8000_0000));
        send_sample(uniform_sample(1'b0, 32'h0));
        send_sample(uniform_sample(1'b0, 32'hffff_ffff));
        drain();

        // Accumulate does not use the bias registers.
        configure(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_sample(uniform_sample(1'b0, 32'd5));
        send_sample(uniform_sample(1'b1, 32'h8000_0000));

        // Random phases, alternating modes; the last one runs without idling.
        for (phase = 0; phase < 8; phase++)
        begin
            drain();
            if (phase == 7)
                idling_on = 1'b0;
            if (phase == 2)
                configure(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
            else if (phase == 3)
                configure(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else
                configure(phase[0], rand_setting(), rand_setting(), rand_setting(),
                          rand_setting());
            for (i = 0; i < 210; i++)
            begin
                // Long output stall while samples keep coming, so the input backs up.
                if (phase == 4 && i == 20)
                    hold_request = 3000;
                // Sender pause until every result is back.
                if (phase == 5 && i == 60)
                    drain();
                send_with_idle(rand_sample());
            end
        end

        drain();
        repeat (400) @(posedge clk);
        $display("Checked %0d results across accumulate and compensate phases with",
                 board.n_checked);
        $display("extreme and random settings: %0d saturated, %0d with no calibration data.",
                 board.n_sat, board.n_empty);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
